/* rtl/softmax_top_k_classifier_assert.svh */
// assertion macros used by the checker file
`ifndef SOFTMAX_TOP_K_CLASSIFIER_ASSERT_SVH
`define SOFTMAX_TOP_K_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SMX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SMX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/smx_pkg.sv */
// types, constants and exp tables for the softmax top-k classifier
package smx_pkg;

    localparam int MAX_CLASSES_DEF = 16;
    localparam int MAX_KEEP_DEF    = 8;
    localparam int PROB_W          = 17;
    localparam int IDX_OUT_W       = 8;
    localparam int NUM_W           = 34;
    localparam logic [3:0] KEEP_RESET = 4'd5;

    typedef struct packed {
        logic signed [31:0] logit_value;
        logic               last_logit;
    } smx_in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] class_index;
        logic [PROB_W-1:0]    probability;
        logic                 last_result;
    } smx_out_t;

    typedef struct packed {
        logic                 valid;
        logic [PROB_W-1:0]    prob;
        logic [IDX_OUT_W-1:0] idx;
    } smx_entry_t;

    typedef struct packed {
        logic shift_en;
        logic clear;
    } smx_cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EXP,
        ST_DIV,
        ST_DRAIN,
        ST_OUT
    } smx_state_t;

    function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] p;
        p = 34'(a) * 34'(b) + 34'd32768;
        return p[32:16];
    endfunction

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd24109;
            4'd2:  v = 17'd8869;
            4'd3:  v = 17'd3263;
            4'd4:  v = 17'd1200;
            4'd5:  v = 17'd442;
            4'd6:  v = 17'd162;
            4'd7:  v = 17'd60;
            4'd8:  v = 17'd22;
            4'd9:  v = 17'd8;
            4'd10: v = 17'd3;
            4'd11: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] j);
        logic [16:0] v;
        case (j)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57835;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32953;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29081;
            4'd14: v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_mid(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd65280;
            4'd2:  v = 17'd65026;
            4'd3:  v = 17'd64772;
            4'd4:  v = 17'd64520;
            4'd5:  v = 17'd64268;
            4'd6:  v = 17'd64018;
            4'd7:  v = 17'd63768;
            4'd8:  v = 17'd63520;
            4'd9:  v = 17'd63272;
            4'd10: v = 17'd63025;
            4'd11: v = 17'd62780;
            4'd12: v = 17'd62535;
            4'd13: v = 17'd62291;
            4'd14: v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

/* rtl/softmax_top_k_classifier.sv */
// Softmax with top-k ranking. Logits load at one transaction per cycle while
// s_ready is high; excess logits past MAX_CLASSES are dropped but a last mark
// still closes the vector. After the last logit the block computes the table
// exp of each class (three chained 17x17 multiplies), then the probability of
// each class (bit-serial divider), then drains to settle the ranking chain of
// MAX_KEEP cells, then delivers the ranked results one per cycle as m_ready
// allows. No logit is taken until the last result has gone.
module softmax_top_k_classifier
    import smx_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int MAX_KEEP    = MAX_KEEP_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  smx_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output smx_out_t m_data,
    input  logic     cfg_we,
    input  logic [3:0] cfg_wdata
);

    localparam int ADDR_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
    localparam int SUM_W  = PROB_W + $clog2(MAX_CLASSES);
    localparam int KEEP_W = $clog2(MAX_KEEP + 1);
    localparam int DRN_W  = $clog2(MAX_KEEP + 1);

    smx_state_t state_reg, state_next;

    logic [3:0]        keep_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       max_reg, max_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [1:0]        step_reg, step_next;
    logic [DRN_W-1:0]  drn_reg, drn_next;
    logic [KEEP_W-1:0] ocnt_reg, ocnt_next;
    logic [KEEP_W-1:0] keep_eff;

    logic [31:0] logit_mem [MAX_CLASSES];
    logic [16:0] exp_mem   [MAX_CLASSES];
    logic [31:0] logit_rd_reg;
    logic [16:0] exp_rd_reg;

    logic [16:0] v_reg, v_next;
    logic [3:0]  k_reg, k_next;
    logic [7:0]  r_reg, r_next;
    logic        zero_reg, zero_next;
    logic [31:0] diff;
    logic [16:0] e_val;

    logic             s_fire, m_fire, store_ok;
    logic             mem_wr, exp_wr;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;

    smx_cell_ctrl_t cell_ctrl;
    smx_entry_t     feed_in;
    smx_entry_t     chain_feed  [MAX_KEEP+1];
    smx_entry_t     chain_store [MAX_KEEP+1];

    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign store_ok = cnt_reg < CNT_W'(MAX_CLASSES);
    assign diff     = max_reg - logit_rd_reg;
    assign e_val    = zero_reg ? 17'd0 : qmul(v_reg, 17'd65536 - {9'd0, r_reg});
    assign div_num  = NUM_W'({exp_rd_reg, 16'd0}) + NUM_W'(sum_reg >> 1);

    // effective number of results: keep clamped to 1..MAX_KEEP, then to count
    always_comb begin
        int k;
        k = int'(keep_reg);
        if (k < 1) k = 1;
        if (k > MAX_KEEP) k = MAX_KEEP;
        if (k > int'(cnt_reg)) k = int'(cnt_reg);
        keep_eff = KEEP_W'(k);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_data.last_logit) begin
                    if (store_ok || cnt_reg != '0) state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                if (step_reg == 2'd3 && idx_reg == ADDR_W'(cnt_reg - 1'b1)) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done && idx_reg == ADDR_W'(cnt_reg - 1'b1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drn_reg == '0) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_fire && ocnt_reg == keep_eff - 1'b1) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        mem_wr    = 1'b0;
        exp_wr    = 1'b0;
        div_start = 1'b0;
        feed_in   = '0;
        cell_ctrl = '0;
        cnt_next  = cnt_reg;
        max_next  = max_reg;
        sum_next  = sum_reg;
        idx_next  = idx_reg;
        step_next = step_reg;
        drn_next  = drn_reg;
        ocnt_next = ocnt_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        r_next    = r_reg;
        zero_next = zero_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                idx_next  = '0;
                step_next = '0;
                sum_next  = '0;
                if (s_fire) begin
                    if (store_ok) begin
                        mem_wr   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == '0 ||
                            $signed(s_data.logit_value) > $signed(max_reg)) begin
                            max_next = s_data.logit_value;
                        end
                    end
                    if (s_data.last_logit && !store_ok && cnt_reg == '0) begin
                        cnt_next = '0;
                        max_next = 32'h8000_0000;
                    end
                end
            end
            ST_EXP: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    2'd1: begin
                        zero_next = diff[31:16] >= 16'd12;
                        v_next    = qmul(exp_int(diff[19:16]), exp_hi(diff[15:12]));
                        k_next    = diff[11:8];
                        r_next    = diff[7:0];
                    end
                    2'd2: v_next = qmul(v_reg, exp_mid(k_reg));
                    2'd3: begin
                        exp_wr   = 1'b1;
                        sum_next = sum_reg + SUM_W'(e_val);
                        idx_next = (idx_reg == ADDR_W'(cnt_reg - 1'b1)) ? '0 : idx_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                case (step_reg)
                    2'd0: step_next = 2'd1;
                    2'd1: begin
                        div_start = 1'b1;
                        step_next = 2'd2;
                    end
                    default: begin
                        if (div_done) begin
                            feed_in.valid = 1'b1;
                            feed_in.prob  = div_quot[PROB_W-1:0];
                            feed_in.idx   = IDX_OUT_W'(idx_reg);
                            idx_next      = idx_reg + 1'b1;
                            step_next     = 2'd0;
                        end
                    end
                endcase
                drn_next  = DRN_W'(MAX_KEEP);
                ocnt_next = '0;
            end
            ST_DRAIN: begin
                drn_next = drn_reg - 1'b1;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_fire) begin
                    cell_ctrl.shift_en = 1'b1;
                    ocnt_next = ocnt_reg + 1'b1;
                    if (ocnt_reg == keep_eff - 1'b1) begin
                        cell_ctrl.clear = 1'b1;
                        cnt_next = '0;
                        max_next = 32'h8000_0000;
                        sum_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            keep_reg  <= KEEP_RESET;
            cnt_reg   <= '0;
            max_reg   <= 32'h8000_0000;
            sum_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            drn_reg   <= '0;
            ocnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) keep_reg <= cfg_wdata;
            cnt_reg  <= cnt_next;
            max_reg  <= max_next;
            sum_reg  <= sum_next;
            idx_reg  <= idx_next;
            step_reg <= step_next;
            drn_reg  <= drn_next;
            ocnt_reg <= ocnt_next;
        end
        v_reg    <= v_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        zero_reg <= zero_next;
    end

    // logit and exp stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (mem_wr) logit_mem[cnt_reg[ADDR_W-1:0]] <= s_data.logit_value;
        logit_rd_reg <= logit_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (exp_wr) exp_mem[idx_reg] <= e_val;
        exp_rd_reg <= exp_mem[idx_reg];
    end

    smx_divider #(
        .DEN_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign chain_feed[0]         = feed_in;
    assign chain_store[MAX_KEEP] = '0;

    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        smx_rank_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .feed     (chain_feed[g]),
            .shift_in (chain_store[g+1]),
            .pass_out (chain_feed[g+1]),
            .stored   (chain_store[g])
        );
    end

    assign m_data.class_index = chain_store[0].idx;
    assign m_data.probability = chain_store[0].prob;
    assign m_data.last_result = (ocnt_reg == keep_eff - 1'b1);

endmodule

/* rtl/smx_rank_cell.sv */
// one cell of the systolic top-k insertion chain
module smx_rank_cell
    import smx_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  smx_cell_ctrl_t ctrl,
    input  smx_entry_t     feed,
    input  smx_entry_t     shift_in,
    output smx_entry_t     pass_out,
    output smx_entry_t     stored
);

    smx_entry_t stored_reg, stored_next;
    smx_entry_t pass_reg, pass_next;

    always_comb begin
        stored_next = stored_reg;
        pass_next   = '0;
        if (ctrl.clear) begin
            stored_next = '0;
        end else if (ctrl.shift_en) begin
            stored_next = shift_in;
        end else if (feed.valid) begin
            if (!stored_reg.valid) begin
                stored_next = feed;
            end else if (feed.prob > stored_reg.prob ||
                         (feed.prob == stored_reg.prob && feed.idx < stored_reg.idx)) begin
                // equal probability ranks the lower index first
                stored_next = feed;
                pass_next   = stored_reg;
            end else begin
                pass_next = feed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg <= '0;
            pass_reg   <= '0;
        end else begin
            stored_reg <= stored_next;
            pass_reg   <= pass_next;
        end
    end

    assign pass_out = pass_reg;
    assign stored   = stored_reg;

endmodule

/* rtl/smx_divider.sv */
// restoring divider, one quotient bit per cycle
module smx_divider
    import smx_pkg::*;
#(
    parameter int DEN_W = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        if (start) begin
            rem_next  = '0;
            num_next  = num;
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/smx_checker.sv */
// port-level checks for the softmax top-k classifier, with its bind
`include "softmax_top_k_classifier_assert.svh"

module smx_checker
    import smx_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input smx_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input smx_out_t m_data
);

    logic in_seen;
    assign in_seen = s_valid && s_data.last_logit;

    // no logit is taken while results are pending
    `SMX_ASSERT_IMP(a_no_load_in_out, aclk, aresetn, m_valid, !s_ready)
    // a ranked run keeps going until its last result
    `SMX_ASSERT_NXT(a_run_continues, aclk, aresetn,
        m_valid && m_ready && !m_data.last_result, m_valid)
    // after the last result the block returns to loading
    `SMX_ASSERT_NXT(a_run_ends, aclk, aresetn,
        m_valid && m_ready && m_data.last_result, !m_valid && s_ready)
    // a result stays put while stalled
    `SMX_ASSERT_NXT(a_hold, aclk, aresetn,
        m_valid && !m_ready && !in_seen, m_valid && $stable(m_data))

endmodule

bind softmax_top_k_classifier smx_checker u_smx_checker (.*);
